/* rtl/core/dbnc_pkg.sv */
package dbnc_pkg;

    localparam int CHANNELS   = 10;
    localparam int COUNT_BITS = 8;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CHAN_BITS  = 4;
    localparam int TIME_BITS  = 8;
    localparam int NUM_REGS   = 7;
    localparam int REG_W      = $clog2(NUM_REGS + 1);
    localparam int ADDR_W     = REG_W + 2;
    localparam int DATA_W     = 32;
    localparam int IN_W       = 8;
    localparam int OUT_W      = 8;

    localparam logic [TIME_BITS-1:0] TIME_RESET = TIME_BITS'(10);

    // register indexes
    localparam logic [REG_W-1:0] REG_POWER_BUTTON    = REG_W'(0);
    localparam logic [REG_W-1:0] REG_ADAPTER         = REG_W'(1);
    localparam logic [REG_W-1:0] REG_BATTERY         = REG_W'(2);
    localparam logic [REG_W-1:0] REG_RECOVERY_BUTTON = REG_W'(3);
    localparam logic [REG_W-1:0] REG_LAN_WAKE        = REG_W'(4);
    localparam logic [REG_W-1:0] REG_LID             = REG_W'(5);
    localparam logic [REG_W-1:0] REG_EXTERNAL        = REG_W'(6);

    typedef enum logic [1:0] {
        EDGE_NONE    = 2'd0,
        EDGE_PRESS   = 2'd1,
        EDGE_RELEASE = 2'd2
    } t_edge;

    typedef struct packed {
        logic                  stable;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
        t_entry          data;
    } t_wr_req;

    function automatic logic chan_in_range(input logic [CHAN_BITS-1:0] ch);
        return ({1'b0, ch} < (CHAN_BITS + 1)'(CHANNELS));
    endfunction

endpackage

/* rtl/core/multi_channel_input_debouncer.sv */
// channel   | direction | beat contents (low bit first)
// s_t*      | in        | tdata: channel[3:0], level[4], hold[5], zero[7:6]
// m_t*      | out       | tdata: source_channel[3:0], edge_res[5:4], stable[6], skipped[7]
// apb       | in/out    | seven 8-bit debounce times at byte address 4*index
//
// one beat per cycle sustained while m_tready holds; a taken beat is registered into the update
// stage as its channel entry is read from the state ram; the update stage then writes the entry
// back and loads the output register; a write to the same entry is bypassed into the read
// reset is synchronous; state entries read as zero until first written (valid bits)
// a stalled output holds the update stage, and s_tready drops once both are full
module multi_channel_input_debouncer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // channel[3:0], level[4], hold[5], zero[7:6]
    input  logic [dbnc_pkg::IN_W-1:0]        s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // source_channel[3:0], edge_res[5:4], stable[6], skipped[7]
    output logic [dbnc_pkg::OUT_W-1:0]       m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dbnc_pkg::ADDR_W-1:0]      paddr,
    input  logic [dbnc_pkg::DATA_W-1:0]      pwdata,
    output logic [dbnc_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import dbnc_pkg::*;

    // update stage
    logic                  r_s1_vld;
    logic [CHAN_BITS-1:0]  r_s1_ch;
    logic                  r_s1_lvl;
    logic                  r_s1_hold;

    // output register
    logic                  r_out_vld;
    logic [CHAN_BITS-1:0]  r_out_ch;
    t_edge                 r_out_edge;
    logic                  r_out_stable;
    logic                  r_out_skipped;

    logic                  w_accept;
    logic                  w_s1_adv;
    logic [CHAN_BITS-1:0]  w_in_ch;
    logic                  w_in_range;
    t_entry                w_rd;
    t_wr_req               w_wr;
    logic [TIME_BITS-1:0]  w_time;
    logic                  w_s1_range;
    t_entry                n_entry;
    t_edge                 n_edge;
    logic                  n_stable;
    logic [COUNT_BITS-1:0] w_dec;

    dbnc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_sel_chan (r_s1_ch),
        .o_sel_time (w_time)
    );

    // handshake: output register frees the update stage, which frees the input
    assign w_s1_adv = r_s1_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_s1_vld || w_s1_adv;
    assign w_accept = s_tvalid && s_tready;

    assign w_in_ch    = s_tdata[CHAN_BITS-1:0];
    assign w_in_range = chan_in_range(w_in_ch);

    dbnc_state_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept && w_in_range),
        .i_rd_addr (w_in_ch[CH_W-1:0]),
        .o_rd_data (w_rd),
        .i_wr      (w_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_tready) begin
            r_s1_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_ch   <= w_in_ch;
            r_s1_lvl  <= s_tdata[CHAN_BITS];
            r_s1_hold <= s_tdata[CHAN_BITS+1];
        end
    end

    // per-channel debounce step on the entry read back from the ram
    assign w_s1_range = chan_in_range(r_s1_ch);
    assign w_dec      = w_rd.count - COUNT_BITS'(1);

    always_comb begin
        n_entry  = w_rd;
        n_edge   = EDGE_NONE;
        n_stable = w_s1_range ? w_rd.stable : 1'b0;
        if (w_s1_range && !r_s1_hold) begin
            if (r_s1_lvl == w_rd.stable) begin
                n_entry.count = '0;
            end else if (w_rd.count == '0) begin
                // load the debounce time, sized to the counter width
                n_entry.count = COUNT_BITS'(w_time);
            end else begin
                n_entry.count = w_dec;
                if (w_dec == '0) begin
                    n_entry.stable = r_s1_lvl;
                    n_stable       = r_s1_lvl;
                    n_edge         = r_s1_lvl ? EDGE_PRESS : EDGE_RELEASE;
                end
            end
        end
    end

    // write back only for a live, in-range, unheld sample
    always_comb begin
        w_wr.en   = w_s1_adv && w_s1_range && !r_s1_hold;
        w_wr.addr = r_s1_ch[CH_W-1:0];
        w_wr.data = n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_ch      <= r_s1_ch;
            r_out_edge    <= n_edge;
            r_out_stable  <= n_stable;
            r_out_skipped <= r_s1_hold;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {r_out_skipped, r_out_stable, r_out_edge, r_out_ch};

    // an edge always agrees with the level it reports
    a_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out_edge != EDGE_NONE) |->
            (r_out_stable == (r_out_edge == EDGE_PRESS)))
        else $error("edge disagrees with stable level");

    // a held tick never reports an edge
    a_skip_no_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_skipped |-> (r_out_edge == EDGE_NONE))
        else $error("edge on a skipped tick");

    // out-of-range channels read as inactive and never report
    a_range_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !chan_in_range(r_out_ch) |->
            (!r_out_stable && (r_out_edge == EDGE_NONE)))
        else $error("out-of-range channel reported state");

    // a held output beat keeps the update stage from writing the ram
    a_stall_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !m_tready |-> !w_wr.en)
        else $error("ram written while output stalled");

    // a ram write always comes from a beat held in the update stage
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> r_s1_vld)
        else $error("ram written with no item in flight");

endmodule

/* rtl/core/dbnc_cfg.sv */
module dbnc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dbnc_pkg::ADDR_W-1:0]      paddr,
    input  logic [dbnc_pkg::DATA_W-1:0]      pwdata,
    output logic [dbnc_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic [dbnc_pkg::CHAN_BITS-1:0]   i_sel_chan,
    output logic [dbnc_pkg::TIME_BITS-1:0]   o_sel_time
);
    import dbnc_pkg::*;

    logic [TIME_BITS-1:0] r_time [NUM_REGS];
    logic [REG_W-1:0]     w_idx;
    logic [REG_W-1:0]     w_sel_idx;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_time[i] <= TIME_RESET;
            end
        end else if (psel && penable && pwrite && pready) begin
            if (w_idx <= REG_EXTERNAL) begin
                r_time[w_idx] <= pwdata[TIME_BITS-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx <= REG_EXTERNAL) begin
            prdata = DATA_W'(r_time[w_idx]);
        end
    end

    // channels six and up share the external time
    always_comb begin
        if ({1'b0, i_sel_chan} < (CHAN_BITS + 1)'(REG_EXTERNAL)) begin
            w_sel_idx = REG_W'(i_sel_chan);
        end else begin
            w_sel_idx = REG_EXTERNAL;
        end
    end

    assign o_sel_time = r_time[w_sel_idx];

endmodule

/* rtl/core/dbnc_state_ram.sv */
module dbnc_state_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [dbnc_pkg::CH_W-1:0]   i_rd_addr,
    output dbnc_pkg::t_entry            o_rd_data,
    input  dbnc_pkg::t_wr_req           i_wr
);
    import dbnc_pkg::*;

    t_entry              r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vbits;
    t_entry              r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // entry never written reads as the reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
        end else if (i_wr.en) begin
            r_vbits[i_wr.addr] <= 1'b1;
        end
    end

    // write-first bypass when the same entry is written on the read edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else if (r_vbits[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
